// File: hdl/lzwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types, constants and helpers of the LZW variable-width decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam int DICT_ENTRIES    = 16384;
  localparam int MAX_CODE_BITS   = 14;
  localparam int VALID_CODE_BITS = 12;

  localparam int ADDR_W = $clog2(DICT_ENTRIES);
  localparam int NF_W   = ADDR_W + 1;
  localparam int CODE_W = MAX_CODE_BITS;
  localparam int CW_W   = 4;

  localparam logic [CODE_W-1:0] CLEAR_CODE = CODE_W'(256);
  localparam logic [CODE_W-1:0] END_CODE   = CODE_W'(257);
  localparam logic [NF_W-1:0]   FIRST_FREE = NF_W'(258);
  localparam logic [CW_W-1:0]   START_BITS = CW_W'(9);
  localparam logic [NF_W-1:0]   VALID_LIMIT = NF_W'(1 << VALID_CODE_BITS);
  localparam logic [NF_W-1:0]   DICT_LIMIT  = NF_W'(DICT_ENTRIES);

  // configuration register indexes
  localparam logic REG_EARLY_CHANGE = 1'b0;
  localparam logic REG_EXT_CODES    = 1'b1;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_BYTE = 3'd1,
    ST_BUSY = 3'd2,
    ST_END  = 3'd3,
    ST_BAD  = 3'd4,
    ST_OVF  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PH_RUN = 2'd0,
    PH_END = 2'd1,
    PH_BAD = 2'd2,
    PH_OVF = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_DEC,
    S_ADD,
    S_WST,
    S_WALK
  } state_e;

  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [7:0]        val;
    logic [7:0]        first;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic    shift_in;
    logic    clear_tbl;
    logic    set_prev_lit;
    logic    widen_pre;
    logic    add_entry;
    logic    set_full;
    logic    set_phase;
    phase_e  phase;
    logic    walk_load;
    logic    rd_code;
    logic    rd_cur;
    logic    rd_prefix;
    logic    walk_step;
    logic    push_cur;
    logic    pop;
    logic    load_out;
    status_e status;
    logic    out_pop;
  } cmd_t;

  typedef struct packed {
    logic   out_free;
    logic   code_rdy;
    logic   sp_zero;
    phase_e phase;
    logic   prev_clear;
    logic   c_clear;
    logic   c_end;
    logic   c_lit;
    logic   can_add;
    logic   nf_full;
    logic   bad_add;
    logic   bad_noadd;
    logic   cur_lit;
    logic   pfx_lit;
  } sts_t;

  function automatic status_e phase_status(phase_e ph);
    status_e s;
    case (ph)
      PH_END:  s = ST_END;
      PH_BAD:  s = ST_BAD;
      default: s = ST_OVF;
    endcase
    return s;
  endfunction

  // grow the code width once the next entry no longer fits below the limit
  function automatic logic [CW_W-1:0] widen(logic [CW_W-1:0] cw, logic [NF_W-1:0] nf,
                                            logic ext);
    logic [CW_W-1:0] cap;
    logic [16:0]     lim;
    cap = ext ? CW_W'(MAX_CODE_BITS) : CW_W'(VALID_CODE_BITS);
    lim = (17'd1 << cw) - 17'd2;
    if (17'(nf) > lim && cw < cap) return cw + 1'b1;
    return cw;
  endfunction

endpackage

// File: hdl/lzwd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/lzwd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_ctrl
// Sequencer: accepts words, steps code decode, table add and chain walk.
// ----------------------------------------------------------------------------
module lzwd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_kind_i,
  output logic           in_ready_o,
  input  lzwd_pkg::sts_t sts_i,
  output lzwd_pkg::cmd_t cmd_o
);

  lzwd_pkg::state_e state_q, state_d;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= lzwd_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  assign in_ready_o = (state_q == lzwd_pkg::S_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.phase  = lzwd_pkg::PH_RUN;
    cmd_o.status = lzwd_pkg::ST_OK;
    case (state_q)
      lzwd_pkg::S_IDLE: begin
        if (accept) begin
          if (in_kind_i) begin
            if (!sts_i.sp_zero) begin
              cmd_o.pop = 1'b1;
              state_d   = lzwd_pkg::S_POP;
            end else begin
              cmd_o.load_out = 1'b1;
              cmd_o.status   = (sts_i.phase == lzwd_pkg::PH_RUN) ? lzwd_pkg::ST_BUSY
                                                                 : lzwd_pkg::phase_status(sts_i.phase);
            end
          end else if (sts_i.phase != lzwd_pkg::PH_RUN) begin
            cmd_o.load_out = 1'b1;
            cmd_o.status   = lzwd_pkg::phase_status(sts_i.phase);
          end else if (!sts_i.sp_zero) begin
            cmd_o.load_out = 1'b1;
            cmd_o.status   = lzwd_pkg::ST_BUSY;
          end else begin
            cmd_o.shift_in = 1'b1;
            if (sts_i.code_rdy) state_d = lzwd_pkg::S_DEC;
            else                cmd_o.load_out = 1'b1;
          end
        end
      end
      lzwd_pkg::S_POP: begin
        cmd_o.load_out = 1'b1;
        cmd_o.out_pop  = 1'b1;
        cmd_o.status   = lzwd_pkg::ST_BYTE;
        state_d        = lzwd_pkg::S_IDLE;
      end
      lzwd_pkg::S_DEC: begin
        state_d = lzwd_pkg::S_IDLE;
        if (sts_i.prev_clear) begin
          cmd_o.clear_tbl = 1'b1;
          if (sts_i.c_clear) begin
            cmd_o.load_out = 1'b1;
          end else if (sts_i.c_end) begin
            cmd_o.set_phase = 1'b1;
            cmd_o.phase     = lzwd_pkg::PH_END;
            cmd_o.load_out  = 1'b1;
            cmd_o.status    = lzwd_pkg::ST_END;
          end else if (!sts_i.c_lit) begin
            cmd_o.set_phase = 1'b1;
            cmd_o.phase     = lzwd_pkg::PH_BAD;
            cmd_o.load_out  = 1'b1;
            cmd_o.status    = lzwd_pkg::ST_BAD;
          end else begin
            cmd_o.set_prev_lit = 1'b1;
            cmd_o.walk_load    = 1'b1;
            state_d            = lzwd_pkg::S_WST;
          end
        end else if (sts_i.c_end) begin
          cmd_o.set_phase = 1'b1;
          cmd_o.phase     = lzwd_pkg::PH_END;
          cmd_o.load_out  = 1'b1;
          cmd_o.status    = lzwd_pkg::ST_END;
        end else if (sts_i.c_clear) begin
          cmd_o.clear_tbl = 1'b1;
          cmd_o.load_out  = 1'b1;
        end else if (sts_i.can_add) begin
          // fetch the first byte of the code's string for the new entry
          cmd_o.widen_pre = 1'b1;
          cmd_o.rd_code   = 1'b1;
          state_d         = lzwd_pkg::S_ADD;
        end else begin
          cmd_o.set_full = 1'b1;
          if (sts_i.bad_noadd) begin
            cmd_o.set_phase = 1'b1;
            cmd_o.phase     = lzwd_pkg::PH_BAD;
            cmd_o.load_out  = 1'b1;
            cmd_o.status    = lzwd_pkg::ST_BAD;
          end else begin
            cmd_o.walk_load = 1'b1;
            state_d         = lzwd_pkg::S_WST;
          end
        end
      end
      lzwd_pkg::S_ADD: begin
        state_d = lzwd_pkg::S_IDLE;
        if (sts_i.nf_full) begin
          cmd_o.set_full  = 1'b1;
          cmd_o.set_phase = 1'b1;
          cmd_o.phase     = lzwd_pkg::PH_OVF;
          cmd_o.load_out  = 1'b1;
          cmd_o.status    = lzwd_pkg::ST_OVF;
        end else begin
          cmd_o.add_entry = 1'b1;
          if (sts_i.bad_add) begin
            cmd_o.set_phase = 1'b1;
            cmd_o.phase     = lzwd_pkg::PH_BAD;
            cmd_o.load_out  = 1'b1;
            cmd_o.status    = lzwd_pkg::ST_BAD;
          end else begin
            cmd_o.walk_load = 1'b1;
            state_d         = lzwd_pkg::S_WST;
          end
        end
      end
      lzwd_pkg::S_WST: begin
        if (sts_i.cur_lit) begin
          cmd_o.push_cur = 1'b1;
          cmd_o.load_out = 1'b1;
          state_d        = lzwd_pkg::S_IDLE;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d      = lzwd_pkg::S_WALK;
        end
      end
      lzwd_pkg::S_WALK: begin
        // push one entry a cycle, chase the prefix until a literal remains
        cmd_o.walk_step = 1'b1;
        if (sts_i.pfx_lit) state_d = lzwd_pkg::S_WST;
        else               cmd_o.rd_prefix = 1'b1;
      end
      default: state_d = lzwd_pkg::S_IDLE;
    endcase
  end

endmodule

// File: hdl/lzwd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_dp
// Datapath: bit buffer, code table, string stack and output register.
// ----------------------------------------------------------------------------
module lzwd_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_addr_i,
  input  logic           cfg_wdata_i,
  input  logic [7:0]     in_byte_i,
  input  lzwd_pkg::cmd_t cmd_i,
  output lzwd_pkg::sts_t sts_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [15:0]    out_data_o,
  output logic           out_last_o
);

  localparam int AW = lzwd_pkg::ADDR_W;
  localparam int NW = lzwd_pkg::NF_W;
  localparam int CW = lzwd_pkg::CODE_W;
  localparam int ENTRY_WL = lzwd_pkg::ENTRY_W;

  logic [23:0]               bit_buf_q, bit_buf_d;
  logic [4:0]                bit_cnt_q, bit_cnt_d;
  logic [lzwd_pkg::CW_W-1:0] cw_q, cw_d;
  logic [NW-1:0]             nf_q, nf_d, sp_q, sp_d;
  logic [CW-1:0]             prev_q, prev_d, code_q, code_d, cur_q, cur_d;
  logic [7:0]                pf_q, pf_d;
  lzwd_pkg::phase_e          phase_q, phase_d;
  logic                      ext_q, ext_d, full_q, full_d;
  logic                      early_q, early_d, extc_q, extc_d;
  logic                      ov_q, ov_d;
  lzwd_pkg::status_e         os_q, os_d;
  logic [7:0]                ob_q, ob_d;
  logic                      od_q, od_d, oe_q, oe_d, of_q, of_d;

  logic [5:0]                cnt_sum;
  logic [23:0]               buf_sh, buf_shr;
  logic [4:0]                shamt;
  logic [CW-1:0]             code_ext;
  logic [NW-1:0]             nf_inc, sp_dec;
  logic                      code_rdy;
  lzwd_pkg::entry_t          rd_ent, wr_ent;
  logic [ENTRY_WL-1:0]       dict_rdata;
  logic [7:0]                fc, stk_rdata, stk_wdata;
  logic                      c_lit, push;
  logic                      dict_re;
  logic [AW-1:0]             dict_raddr;

  assign cnt_sum  = {1'b0, bit_cnt_q} + 6'd8;
  assign code_rdy = cnt_sum >= {2'b00, cw_q};
  assign buf_sh   = {bit_buf_q[15:0], in_byte_i};
  assign shamt    = 5'(cnt_sum - {2'b00, cw_q});
  assign buf_shr  = buf_sh >> shamt;
  assign code_ext = buf_shr[CW-1:0] & ((CW'(1) << cw_q) - CW'(1));
  assign nf_inc   = nf_q + 1'b1;
  assign sp_dec   = sp_q - 1'b1;
  assign rd_ent   = lzwd_pkg::entry_t'(dict_rdata);
  assign c_lit    = (code_q[CW-1:8] == '0);
  // first byte of the code's string; a code equal to the next free entry repeats prev
  assign fc = c_lit ? code_q[7:0] : ((NW'(code_q) < nf_q) ? rd_ent.first : pf_q);

  assign sts_o.out_free   = !ov_q || out_ready_i;
  assign sts_o.code_rdy   = code_rdy;
  assign sts_o.sp_zero    = (sp_q == '0);
  assign sts_o.phase      = phase_q;
  assign sts_o.prev_clear = (prev_q == lzwd_pkg::CLEAR_CODE);
  assign sts_o.c_clear    = (code_q == lzwd_pkg::CLEAR_CODE);
  assign sts_o.c_end      = (code_q == lzwd_pkg::END_CODE);
  assign sts_o.c_lit      = c_lit;
  assign sts_o.can_add    = (nf_q < lzwd_pkg::VALID_LIMIT) || extc_q;
  assign sts_o.nf_full    = (nf_q >= lzwd_pkg::DICT_LIMIT);
  assign sts_o.bad_add    = !c_lit && (NW'(code_q) >= nf_inc);
  assign sts_o.bad_noadd  = !c_lit && (NW'(code_q) >= nf_q);
  assign sts_o.cur_lit    = (cur_q[CW-1:8] == '0);
  assign sts_o.pfx_lit    = (rd_ent.prefix[CW-1:8] == '0);

  assign wr_ent.prefix = prev_q;
  assign wr_ent.val    = fc;
  assign wr_ent.first  = pf_q;

  assign dict_re    = cmd_i.rd_code || cmd_i.rd_cur || cmd_i.rd_prefix;
  assign dict_raddr = cmd_i.rd_code ? code_q[AW-1:0] :
                      cmd_i.rd_cur  ? cur_q[AW-1:0]  : rd_ent.prefix[AW-1:0];

  assign push      = cmd_i.walk_step || cmd_i.push_cur;
  assign stk_wdata = cmd_i.walk_step ? rd_ent.val : cur_q[7:0];

  lzwd_ram #(.WIDTH(ENTRY_WL), .DEPTH(lzwd_pkg::DICT_ENTRIES)) u_dict (
    .clk_i   (clk_i),
    .we_i    (cmd_i.add_entry),
    .waddr_i (nf_q[AW-1:0]),
    .wdata_i (wr_ent),
    .re_i    (dict_re),
    .raddr_i (dict_raddr),
    .rdata_o (dict_rdata)
  );

  lzwd_ram #(.WIDTH(8), .DEPTH(lzwd_pkg::DICT_ENTRIES)) u_stack (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (sp_q[AW-1:0]),
    .wdata_i (stk_wdata),
    .re_i    (cmd_i.pop),
    .raddr_i (sp_dec[AW-1:0]),
    .rdata_o (stk_rdata)
  );

  always_comb begin
    bit_buf_d = bit_buf_q;
    bit_cnt_d = bit_cnt_q;
    cw_d      = cw_q;
    nf_d      = nf_q;
    prev_d    = prev_q;
    pf_d      = pf_q;
    code_d    = code_q;
    cur_d     = cur_q;
    phase_d   = phase_q;
    sp_d      = sp_q;
    ext_d     = ext_q;
    full_d    = full_q;
    early_d   = early_q;
    extc_d    = extc_q;
    ov_d      = ov_q;
    os_d      = os_q;
    ob_d      = ob_q;
    od_d      = od_q;
    oe_d      = oe_q;
    of_d      = of_q;

    if (cmd_i.shift_in) begin
      bit_buf_d = buf_sh;
      bit_cnt_d = code_rdy ? 5'(cnt_sum - {2'b00, cw_q}) : 5'(cnt_sum);
      code_d    = code_ext;
    end
    if (cmd_i.clear_tbl) begin
      nf_d   = lzwd_pkg::FIRST_FREE;
      cw_d   = lzwd_pkg::START_BITS;
      prev_d = lzwd_pkg::CLEAR_CODE;
    end
    if (cmd_i.set_prev_lit) begin
      prev_d = code_q;
      pf_d   = code_q[7:0];
    end
    if (cmd_i.widen_pre && !early_q) cw_d = lzwd_pkg::widen(cw_q, nf_q, extc_q);
    if (cmd_i.add_entry) begin
      nf_d   = nf_inc;
      prev_d = code_q;
      pf_d   = fc;
      if (early_q) cw_d = lzwd_pkg::widen(cw_q, nf_inc, extc_q);
      if (nf_q >= lzwd_pkg::VALID_LIMIT) ext_d = 1'b1;
    end
    if (cmd_i.set_full)  full_d  = 1'b1;
    if (cmd_i.set_phase) phase_d = cmd_i.phase;
    if (cmd_i.walk_load) cur_d   = code_q;
    if (cmd_i.walk_step) cur_d   = rd_ent.prefix;
    if (push)            sp_d    = sp_q + 1'b1;
    if (cmd_i.pop)       sp_d    = sp_dec;

    if (cmd_i.load_out) begin
      ov_d = 1'b1;
      os_d = cmd_i.status;
      ob_d = cmd_i.out_pop ? stk_rdata : 8'd0;
      od_d = cmd_i.out_pop && (sp_q == '0);
      oe_d = ext_d;
      of_d = full_d;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end

    if (cfg_we_i) begin
      if (cfg_addr_i == lzwd_pkg::REG_EARLY_CHANGE) early_d = cfg_wdata_i;
      else                                          extc_d  = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_buf_q <= '0;
      bit_cnt_q <= '0;
      cw_q      <= lzwd_pkg::START_BITS;
      nf_q      <= lzwd_pkg::FIRST_FREE;
      prev_q    <= lzwd_pkg::CLEAR_CODE;
      phase_q   <= lzwd_pkg::PH_RUN;
      sp_q      <= '0;
      ext_q     <= 1'b0;
      full_q    <= 1'b0;
      early_q   <= 1'b1;
      extc_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      bit_buf_q <= bit_buf_d;
      bit_cnt_q <= bit_cnt_d;
      cw_q      <= cw_d;
      nf_q      <= nf_d;
      prev_q    <= prev_d;
      phase_q   <= phase_d;
      sp_q      <= sp_d;
      ext_q     <= ext_d;
      full_q    <= full_d;
      early_q   <= early_d;
      extc_q    <= extc_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pf_q   <= pf_d;
    code_q <= code_d;
    cur_q  <= cur_d;
    os_q   <= os_d;
    ob_q   <= ob_d;
    od_q   <= od_d;
    oe_q   <= oe_d;
    of_q   <= of_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = {3'b000, of_q, oe_q, ob_q, os_q};
  assign out_last_o  = od_q;

endmodule

// File: hdl/lzw_variable_width_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder_core
// LZW decoder for MSB-first variable-width codes with a pull-out string stack.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | tuser kind, tdata in_byte
//  m_axis   | out       | tdata status/out_byte/ext_code_used/dict_full, tlast string_done
//  cfg      | in        | we, index (0 early_change, 1 extended_codes), data
//
//  A push that completes no code, and a refused word, are answered straight from idle;
//  a pop passes through S_POP. A push that completes a code goes through S_DEC, then
//  S_ADD when it adds an entry; a code naming a table entry then walks its prefix
//  chain one entry per read, set by the single read port of the code table.
//  Reset is asynchronous and needs no clearing pass: the table is only read where
//  written. The result register frees s_axis as soon as m_axis takes the word.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] status, [10:3] out_byte,
                                      // [11] ext_code_used, [12] dict_full
  output logic        m_axis_tlast,   // string_done
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic        cfg_wdata_i
);

  lzwd_pkg::cmd_t cmd;
  lzwd_pkg::sts_t sts;

  lzwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lzwd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_byte_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // never take a word while the result register stays blocked
  a_ready_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
    else $error("input taken while result blocked");

  // only a delivered byte carries data or ends a string
  a_byte_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[2:0] != lzwd_pkg::ST_BYTE)) |->
      (m_axis_tdata[10:3] == 8'd0 && !m_axis_tlast))
    else $error("byte or string end on a non-byte result");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LZW variable-width decoder core. Builds MSB-first
// code streams that track the decoder's width and table growth, pushes them a
// word at a time and pulls every decoded byte. A scoreboard class predicts each
// result word and compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module testbench;
  import lzwd_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;

  typedef struct {
    status_e    st;
    logic [7:0] ob;
    logic       done;
    logic       xu;
    logic       df;
  } lzw_word_t;

  class lzw_scoreboard;
    logic [13:0] pfx [DICT_ENTRIES];
    logic [7:0]  val [DICT_ENTRIES];
    logic [7:0]  fst [DICT_ENTRIES];
    logic [7:0]  stk [DICT_ENTRIES];
    int unsigned bbuf, bcnt, cw, nf, prev, sp;
    phase_e      ph;
    bit          ext_used, full, ec, ext;
    lzw_word_t   expq[$];
    int          errors;

    function new();
      bbuf = 0; bcnt = 0; cw = 9; nf = 258; prev = 256; sp = 0;
      ph = PH_RUN; ext_used = 0; full = 0; ec = 1; ext = 0; errors = 0;
    endfunction

    function int unsigned first_of(int unsigned code);
      return (code < 256) ? code : fst[code];
    endfunction

    function void grow();
      int unsigned cap;
      cap = ext ? 14 : 12;
      if (nf > (1 << cw) - 2 && cw < cap) cw++;
    endfunction

    // load the string of a code onto the stack, last byte first
    function void stack_string(int unsigned code);
      int unsigned cur, guard;
      cur = code; guard = 0; sp = 0;
      while (cur >= 256 && guard < DICT_ENTRIES) begin
        stk[sp] = val[cur]; sp++;
        cur = pfx[cur]; guard++;
      end
      if (cur < 256) begin
        stk[sp] = cur[7:0]; sp++;
      end
    endfunction

    function void restart_table();
      nf = 258; cw = 9; prev = 256;
    endfunction

    function status_e decode_code(int unsigned c);
      int unsigned v;
      if (prev == 256) begin
        restart_table();
        if (c == 256) return ST_OK;
        if (c == 257) begin
          ph = PH_END; return ST_END;
        end
        if (c >= 258) begin
          ph = PH_BAD; return ST_BAD;
        end
        stack_string(c);
        prev = c;
        return ST_OK;
      end
      if (c == 257) begin
        ph = PH_END; return ST_END;
      end
      if (c == 256) begin
        restart_table(); return ST_OK;
      end
      if (nf < 4096 || ext) begin
        if (!ec) grow();
        if (nf >= DICT_ENTRIES) begin
          full = 1; ph = PH_OVF; return ST_OVF;
        end
        v = (c < nf) ? first_of(c) : first_of(prev);
        pfx[nf] = prev[13:0];
        fst[nf] = first_of(prev);
        val[nf] = v[7:0];
        if (nf > 4095) ext_used = 1;
        nf++;
        if (ec) grow();
        prev = c;
      end else begin
        full = 1;
      end
      if (c >= 256 && c >= nf) begin
        ph = PH_BAD; return ST_BAD;
      end
      stack_string(c);
      return ST_OK;
    endfunction

    function status_e halted_status();
      case (ph)
        PH_END:  return ST_END;
        PH_BAD:  return ST_BAD;
        default: return ST_OVF;
      endcase
    endfunction

    function void note_input(bit kind, logic [7:0] b);
      lzw_word_t   w;
      int unsigned c;
      w.st = ST_BUSY; w.ob = 8'd0; w.done = 1'b0;
      if (kind) begin
        if (sp > 0) begin
          sp--;
          w.ob = stk[sp]; w.done = (sp == 0); w.st = ST_BYTE;
        end else if (ph != PH_RUN) begin
          w.st = halted_status();
        end
      end else if (ph != PH_RUN) begin
        w.st = halted_status();
      end else if (sp == 0) begin
        bbuf = ((bbuf << 8) | b) & 24'hFFFFFF;
        bcnt += 8;
        w.st = ST_OK;
        if (bcnt >= cw) begin
          c = (bbuf >> (bcnt - cw)) & ((1 << cw) - 1);
          bcnt -= cw;
          w.st = decode_code(c);
        end
      end
      w.xu = ext_used; w.df = full;
      expq.push_back(w);
    endfunction

    function void check_word(logic [15:0] d, logic last);
      lzw_word_t w;
      if (expq.size() == 0) begin
        $error("unexpected result word %h", d);
        errors++;
        return;
      end
      w = expq.pop_front();
      if (d[2:0] !== w.st) begin
        $error("status: expected %0d, got %0d", w.st, d[2:0]); errors++;
      end
      if (d[10:3] !== w.ob) begin
        $error("out_byte: expected %0d, got %0d", w.ob, d[10:3]); errors++;
      end
      if (last !== w.done) begin
        $error("string_done: expected %0d, got %0d", w.done, last); errors++;
      end
      if (d[11] !== w.xu) begin
        $error("ext_code_used: expected %0d, got %0d", w.xu, d[11]); errors++;
      end
      if (d[12] !== w.df) begin
        $error("dict_full: expected %0d, got %0d", w.df, d[12]); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_valid, s_user, m_ready;
  logic [7:0]  s_data;
  logic        cfg_we, cfg_addr, cfg_wdata;
  logic        s_axis_tready, m_axis_tvalid, m_axis_tlast;
  logic [15:0] m_axis_tdata;

  lzw_scoreboard sb = new();

  // stream generator view of the decoder
  int unsigned gw, gnf;
  bit          gclr;
  bit          bitq[$];
  bit          fast;
  int          burst_left;
  int unsigned cyc, idle_cycles;
  int          rx_mode;

  lzw_variable_width_decoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // receiver stall pattern: one of four modes picked at random, always ready when fast
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc % 64 == 0) rx_mode <= $urandom_range(0, 3);
    if (fast) begin
      m_ready <= 1'b1;
    end else begin
      case (rx_mode)
        0:       m_ready <= 1'b1;
        1:       m_ready <= 1'($urandom_range(0, 1));
        2:       m_ready <= (cyc[1:0] == 2'd0);
        default: m_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_ready) sb.check_word(m_axis_tdata, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  task automatic send_word(bit kind, logic [7:0] b);
    int gap;
    if (!fast) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          s_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(kind, b);
  endtask

  // push one compressed word, then pull out whatever string it completed
  task automatic push_byte(logic [7:0] b, bit noisy);
    send_word(1'b0, b);
    if (sb.sp > 0) begin
      if (noisy || $urandom_range(0, 15) == 0) send_word(1'b0, 8'($urandom));
      while (sb.sp > 0) send_word(1'b1, 8'($urandom));
    end else if (noisy || $urandom_range(0, 15) == 0) begin
      send_word(1'b1, 8'($urandom));
    end
  endtask

  task automatic flush_bits(bit noisy);
    logic [7:0] b;
    while (bitq.size() >= 8) begin
      for (int i = 7; i >= 0; i--) b[i] = bitq.pop_front();
      push_byte(b, noisy);
    end
  endtask

  function automatic void gen_grow();
    int unsigned cap;
    cap = sb.ext ? 14 : 12;
    if (gnf > (1 << gw) - 2 && gw < cap) gw++;
  endfunction

  task automatic emit_code(int unsigned c, bit noisy = 0);
    for (int i = gw - 1; i >= 0; i--) bitq.push_back(c[i]);
    if (c == 256) begin
      gw = 9; gnf = 258; gclr = 1;
    end else if (gclr) begin
      gclr = 0;
    end else if (c != 257 && (gnf < 4096 || sb.ext)) begin
      if (!sb.ec) gen_grow();
      gnf++;
      if (sb.ec) gen_grow();
    end
    flush_bits(noisy);
  endtask

  function automatic int unsigned pick_code(int lit_pct);
    int unsigned hi;
    bit          adding;
    if (gclr || $urandom_range(0, 99) < lit_pct) return $urandom_range(0, 255);
    adding = gnf < 4096 || sb.ext;
    hi = adding ? gnf : gnf - 1;
    if (hi > (1 << gw) - 1) hi = (1 << gw) - 1;
    if (adding && $urandom_range(0, 9) == 0) return hi;
    return $urandom_range(258, hi);
  endfunction

  // clear the table and pad with clears until the stream sits on a word boundary
  task automatic align_stream();
    emit_code(int'(CLEAR_CODE));
    while (bitq.size() != 0) emit_code(int'(CLEAR_CODE));
  endtask

  task automatic hold_idle();
    s_valid <= 1'b0;
    while (sb.expq.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_config(bit ec, bit ext);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_EARLY_CHANGE;
    cfg_wdata <= ec;
    @(posedge clk_i);
    cfg_addr  <= REG_EXT_CODES;
    cfg_wdata <= ext;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.ec  = ec;
    sb.ext = ext;
  endtask

  initial begin
    int combo, ending;
    s_valid = 1'b0; s_user = 1'b0; s_data = 8'd0; m_ready = 1'b0;
    cfg_we = 1'b0; cfg_addr = 1'b0; cfg_wdata = 1'b0;
    rst_ni = 1'b0; fast = 0; burst_left = 0; cyc = 0; idle_cycles = 0; rx_mode = 0;
    gw = 9; gnf = 258; gclr = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: repeated clear, extreme literals, KwKwK, mid-stream clear
    write_config(1'b1, 1'b0);
    send_word(1'b1, 8'hFF);
    emit_code(256, 1); emit_code(256, 1); emit_code(0, 1); emit_code(255, 1);
    emit_code(259, 1); emit_code(258, 1); emit_code(256, 1); emit_code(255, 1);
    emit_code(1, 1);
    align_stream();
    hold_idle();

    for (int p = 0; p < 6; p++) begin
      combo = (p < 4) ? p : $urandom_range(0, 3);
      write_config(combo[0], combo[1]);
      for (int n = 0; n < 20; n++)
        emit_code(($urandom_range(0, 49) == 0) ? 256 : pick_code(40));
      align_stream();
      hold_idle();
    end

    // stop the stream by an end code or by an invalid code
    fast = 1;
    ending = $urandom_range(0, 1);
    case (ending)
      0: emit_code(int'(END_CODE));
      default: begin
        align_stream();
        emit_code($urandom_range(0, 255));
        emit_code($urandom_range(0, 255));
        emit_code(gnf + 1);
      end
    endcase
    while (bitq.size() % 8 != 0) bitq.push_back(1'b0);
    flush_bits(0);
    fast = 0;

    // the core stays stopped: everything after this repeats the stop status
    repeat (20) send_word(1'($urandom_range(0, 1)), 8'($urandom));
    hold_idle();
    repeat (50) @(posedge clk_i);

    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
